// ----- sv/csa_pkg.sv -----
// ----------------------------------------------------------------------------
// csa_pkg
// Shared types and constants of the connection slot allocator.
// ----------------------------------------------------------------------------
package csa_pkg;

  // table geometry
  localparam int unsigned SLOTS  = 64;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);

  // fixed field widths of the words
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned PEER_W = 32;

  // request codes
  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_GET    = 2'd3
  } action_e;

  // result codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_UNUSED    = 2'd3
  } status_e;

endpackage

// ----- sv/csa_if.sv -----
// ----------------------------------------------------------------------------
// csa_in_if / csa_out_if
// Valid/ready channels for request and result words of the slot allocator.
// ----------------------------------------------------------------------------
interface csa_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [1:0]                    action;
  logic signed [csa_pkg::PEER_W-1:0]    peer_address;
  logic        [csa_pkg::IDX_W-1:0]     slot_index;

  modport source (output valid, action, peer_address, slot_index, input ready);
  modport sink   (input valid, action, peer_address, slot_index, output ready);
endinterface

interface csa_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [1:0]                    status;
  logic        [csa_pkg::IDX_W-1:0]     result_slot;
  logic signed [csa_pkg::PEER_W-1:0]    result_peer;
  logic                                 table_full;

  modport source (output valid, status, result_slot, result_peer, table_full,
                  input ready);
  modport sink   (input valid, status, result_slot, result_peer, table_full,
                  output ready);
endinterface

// ----- sv/connection_slot_allocator_top.sv -----
// ----------------------------------------------------------------------------
// connection_slot_allocator_top
// Peer slot table with a LIFO free list, held in two single-port-read RAMs.
// ----------------------------------------------------------------------------
// Free and error answers go straight to S_OUT, add and get pass S_ADD or
//   S_GET, remove by peer scans in S_SCAN reading one table entry per cycle
// throughput: one request at a time; a new request is taken once the result
//   has moved to the output register, while that result may still wait
// reset: control and used bits clear, the free count is SLOTS, all at once;
//   the free list order comes from per-entry written flags, no clear needed
module connection_slot_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  csa_in_if.sink      in_i,
  csa_out_if.source   out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_GET,
    S_SCAN,
    S_OUT
  } state_e;

  localparam int unsigned SW = csa_pkg::SLOT_W;
  localparam int unsigned CW = csa_pkg::CNT_W;
  localparam int unsigned PW = csa_pkg::PEER_W;
  localparam int unsigned IW = csa_pkg::IDX_W;

  // memories
  logic [PW-1:0] peer_mem [csa_pkg::SLOTS];
  logic [SW-1:0] stk_mem  [csa_pkg::SLOTS];

  // control registers
  state_e                 state_q, state_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [csa_pkg::SLOTS-1:0] used_q, used_d;
  logic [csa_pkg::SLOTS-1:0] stk_wr_q;
  logic [SW-1:0]          scan_q, scan_d;
  logic                   chk_vld_q, chk_vld_d;
  logic [SW-1:0]          chk_idx_q, chk_idx_d;
  logic                   out_valid_q, out_valid_d;

  // payload registers
  logic [PW-1:0]          peer_q, peer_d;
  csa_pkg::status_e       res_status_q, res_status_d;
  logic [SW-1:0]          res_slot_q, res_slot_d;
  logic [PW-1:0]          res_peer_q, res_peer_d;
  csa_pkg::status_e       out_status_q, out_status_d;
  logic [IW-1:0]          out_slot_q, out_slot_d;
  logic [PW-1:0]          out_peer_q, out_peer_d;
  logic                   out_full_q, out_full_d;

  // memory ports
  logic          peer_we, peer_re;
  logic [SW-1:0] peer_waddr, peer_raddr;
  logic [PW-1:0] peer_rdata_q;
  logic          stk_we, stk_re;
  logic [SW-1:0] stk_waddr, stk_raddr, stk_wdata;
  logic [SW-1:0] stk_rdata_q, stk_defval_q;
  logic          stk_def_q;

  logic          idx_ok;
  logic [SW-1:0] idx;
  logic [SW-1:0] pop_slot;

  assign idx      = in_i.slot_index[SW-1:0];
  assign idx_ok   = (32'(in_i.slot_index) < csa_pkg::SLOTS);
  assign pop_slot = stk_def_q ? stk_defval_q : stk_rdata_q;

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.result_slot = out_slot_q;
  assign out_o.result_peer = out_peer_q;
  assign out_o.table_full  = out_full_q;

  // next state and memory controls
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    used_d       = used_q;
    scan_d       = scan_q;
    chk_vld_d    = chk_vld_q;
    chk_idx_d    = chk_idx_q;
    peer_d       = peer_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_peer_d   = res_peer_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_peer_d   = out_peer_q;
    out_full_d   = out_full_q;
    peer_we      = 1'b0;
    peer_re      = 1'b0;
    peer_waddr   = '0;
    peer_raddr   = '0;
    stk_we       = 1'b0;
    stk_re       = 1'b0;
    stk_waddr    = '0;
    stk_raddr    = '0;
    stk_wdata    = '0;

    // output word taken
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          res_status_d = csa_pkg::ST_OK;
          res_slot_d   = '0;
          res_peer_d   = '0;
          peer_d       = in_i.peer_address;
          case (csa_pkg::action_e'(in_i.action))
            csa_pkg::ACT_ADD: begin
              if (cnt_q == '0) begin
                res_status_d = csa_pkg::ST_FULL;
                state_d      = S_OUT;
              end else begin
                stk_re    = 1'b1;
                stk_raddr = SW'(cnt_q - CW'(1));
                state_d   = S_ADD;
              end
            end
            csa_pkg::ACT_FREE: begin
              if (idx_ok && used_q[idx]) begin
                stk_we      = 1'b1;
                stk_waddr   = SW'(cnt_q);
                stk_wdata   = idx;
                used_d[idx] = 1'b0;
                cnt_d       = cnt_q + CW'(1);
                res_slot_d  = idx;
              end else begin
                res_status_d = csa_pkg::ST_UNUSED;
              end
              state_d = S_OUT;
            end
            csa_pkg::ACT_REMOVE: begin
              scan_d    = '0;
              chk_vld_d = 1'b0;
              state_d   = S_SCAN;
            end
            csa_pkg::ACT_GET: begin
              if (idx_ok && used_q[idx]) begin
                peer_re    = 1'b1;
                peer_raddr = idx;
                res_slot_d = idx;
                state_d    = S_GET;
              end else begin
                res_status_d = csa_pkg::ST_UNUSED;
                state_d      = S_OUT;
              end
            end
            default: begin
              res_status_d = csa_pkg::ST_UNUSED;
              state_d      = S_OUT;
            end
          endcase
        end
      end

      // pop: store the peer in the slot from the top of the free list
      S_ADD: begin
        peer_we          = 1'b1;
        peer_waddr       = pop_slot;
        used_d[pop_slot] = 1'b1;
        cnt_d            = cnt_q - CW'(1);
        res_slot_d       = pop_slot;
        state_d          = S_OUT;
      end

      S_GET: begin
        res_peer_d = peer_rdata_q;
        state_d    = S_OUT;
      end

      // scan: one read issued per cycle, compared in the cycle after
      S_SCAN: begin
        if (chk_vld_q && used_q[chk_idx_q] && (peer_rdata_q == peer_q)) begin
          stk_we            = 1'b1;
          stk_waddr         = SW'(cnt_q);
          stk_wdata         = chk_idx_q;
          used_d[chk_idx_q] = 1'b0;
          cnt_d             = cnt_q + CW'(1);
          res_slot_d        = chk_idx_q;
          state_d           = S_OUT;
        end else if (chk_vld_q && (32'(chk_idx_q) == csa_pkg::SLOTS - 1)) begin
          res_status_d = csa_pkg::ST_NOT_FOUND;
          state_d      = S_OUT;
        end else begin
          peer_re    = 1'b1;
          peer_raddr = scan_q;
          chk_vld_d  = 1'b1;
          chk_idx_d  = scan_q;
          scan_d     = scan_q + SW'(1);
        end
      end

      // hand the result to the output register
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = IW'(res_slot_q);
          out_peer_d   = res_peer_q;
          out_full_d   = (cnt_q == '0);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= CW'(csa_pkg::SLOTS);
      used_q      <= '0;
      scan_q      <= '0;
      chk_vld_q   <= 1'b0;
      chk_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      used_q      <= used_d;
      scan_q      <= scan_d;
      chk_vld_q   <= chk_vld_d;
      chk_idx_q   <= chk_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    peer_q       <= peer_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_peer_q   <= res_peer_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_peer_q   <= out_peer_d;
    out_full_q   <= out_full_d;
  end

  // peer table ram
  always_ff @(posedge clk_i) begin
    if (peer_we) begin
      peer_mem[peer_waddr] <= peer_q;
    end
    if (peer_re) begin
      peer_rdata_q <= peer_mem[peer_raddr];
    end
  end

  // free list ram
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_q  <= stk_mem[stk_raddr];
      stk_defval_q <= SW'(csa_pkg::SLOTS - 1 - 32'(stk_raddr));
    end
  end

  // free list written flags: an unwritten entry reads its reset order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stk_wr_q  <= '0;
      stk_def_q <= 1'b1;
    end else begin
      if (stk_we) begin
        stk_wr_q[stk_waddr] <= 1'b1;
      end
      if (stk_re) begin
        stk_def_q <= !stk_wr_q[stk_raddr];
      end
    end
  end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for connection_slot_allocator_top. A transaction model
// of the slot table and its LIFO free list predicts each result word. Results
// are compared field by field, in order. Both channels stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS       = csa_pkg::SLOTS;
  localparam int unsigned IDX_W       = csa_pkg::IDX_W;
  localparam int unsigned PEER_W      = csa_pkg::PEER_W;

  localparam int unsigned CLK_PERIOD  = 8;
  localparam int unsigned RESET_LEN   = 10;
  localparam int unsigned IDLE_PCT    = 32;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned POOL_SIZE   = 8;

  localparam logic signed [PEER_W-1:0] PEER_MIN  = {1'b1, {(PEER_W-1){1'b0}}};
  localparam logic signed [PEER_W-1:0] PEER_MAX  = {1'b0, {(PEER_W-1){1'b1}}};
  localparam logic signed [PEER_W-1:0] PEER_ONES = '1;

  // one expected result word
  typedef struct packed {
    logic [1:0]               status;
    logic [IDX_W-1:0]         slot;
    logic signed [PEER_W-1:0] peer;
    logic                     full;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n;

  csa_in_if  req_if ();
  csa_out_if rsp_if ();

  connection_slot_allocator_top u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // slot table model
  logic signed [PEER_W-1:0] tbl_peer [SLOTS];
  logic                     tbl_used [SLOTS];
  logic [IDX_W-1:0]         free_stack [SLOTS];
  int unsigned              free_cnt;

  answer_t                  pending_answers [$];
  logic signed [PEER_W-1:0] peer_pool [POOL_SIZE];
  int unsigned              error_count = 0;
  int unsigned              cycle_count = 0;
  bit                       send_idle_en;
  bit                       recv_idle_en;

  // clock
  always #(CLK_PERIOD / 2) clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic void table_reset();
    int i;
    for (i = 0; i < SLOTS; i++) begin
      tbl_peer[i]   = '0;
      tbl_used[i]   = 1'b0;
      free_stack[i] = IDX_W'(SLOTS - 1 - i);
    end
    free_cnt = SLOTS;
  endfunction

  // push a slot back on top of the free list
  function automatic void release_slot(int unsigned slot);
    if (free_cnt < SLOTS) begin
      free_stack[free_cnt] = IDX_W'(slot);
      free_cnt++;
    end
    tbl_used[slot] = 1'b0;
  endfunction

  function automatic answer_t allocator_answer(csa_pkg::action_e act,
                                               logic signed [PEER_W-1:0] peer,
                                               logic [IDX_W-1:0] idx);
    answer_t     a;
    int unsigned slot;
    int          i;
    a.status = csa_pkg::ST_OK;
    a.slot   = '0;
    a.peer   = '0;
    case (act)
      csa_pkg::ACT_ADD: begin
        if (free_cnt == 0) begin
          a.status = csa_pkg::ST_FULL;
        end else begin
          free_cnt--;
          slot           = free_stack[free_cnt];
          tbl_peer[slot] = peer;
          tbl_used[slot] = 1'b1;
          a.slot         = IDX_W'(slot);
        end
      end
      csa_pkg::ACT_FREE: begin
        if (idx < SLOTS && tbl_used[idx]) begin
          release_slot(idx);
          a.slot = idx;
        end else begin
          a.status = csa_pkg::ST_UNUSED;
        end
      end
      csa_pkg::ACT_REMOVE: begin
        // lowest used slot holding the address wins
        a.status = csa_pkg::ST_NOT_FOUND;
        for (i = 0; i < SLOTS; i++) begin
          if (a.status == csa_pkg::ST_NOT_FOUND && tbl_used[i] &&
              tbl_peer[i] == peer) begin
            release_slot(i);
            a.slot   = IDX_W'(i);
            a.status = csa_pkg::ST_OK;
          end
        end
      end
      default: begin
        if (idx < SLOTS && tbl_used[idx]) begin
          a.slot = idx;
          a.peer = tbl_peer[idx];
        end else begin
          a.status = csa_pkg::ST_UNUSED;
        end
      end
    endcase
    a.full = (free_cnt == 0);
    return a;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // receiver stalls
  always @(negedge clk) begin
    if (recv_idle_en) begin
      rsp_if.ready <= ($urandom_range(99) >= IDLE_PCT);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    answer_t want;
    if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected word", rsp_if.status, 0);
      end else begin
        want = pending_answers.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch("status", rsp_if.status, want.status);
        if (rsp_if.result_slot !== want.slot)
          report_mismatch("result_slot", rsp_if.result_slot, want.slot);
        if (rsp_if.result_peer !== want.peer)
          report_mismatch("result_peer", $unsigned(rsp_if.result_peer),
                          $unsigned(want.peer));
        if (rsp_if.table_full !== want.full)
          report_mismatch("table_full", rsp_if.table_full, want.full);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // drive one request word and predict its result once accepted
  task automatic send_word(csa_pkg::action_e act, logic signed [PEER_W-1:0] peer,
                           logic [IDX_W-1:0] idx);
    @(negedge clk);
    while (send_idle_en && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= act;
    req_if.peer_address <= peer;
    req_if.slot_index   <= idx;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    pending_answers.push_back(allocator_answer(act, peer, idx));
  endtask

  // hold off until every pending result has come back
  task automatic drain_results();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // a used slot when there is one, else any index
  function automatic logic [IDX_W-1:0] pick_used_slot();
    logic [IDX_W-1:0] idx;
    idx = IDX_W'($urandom_range(SLOTS - 1));
    if (free_cnt == SLOTS) return idx;
    while (!tbl_used[idx]) idx = idx + 1'b1;
    return idx;
  endfunction

  // mix of repeated, extreme and fully random addresses
  function automatic logic signed [PEER_W-1:0] pick_peer();
    case ($urandom_range(3))
      0: return peer_pool[$urandom_range(POOL_SIZE - 1)];
      1: begin
        case ($urandom_range(3))
          0: return PEER_MIN;
          1: return PEER_MAX;
          2: return '0;
          default: return PEER_ONES;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random_word(int unsigned add_pct);
    csa_pkg::action_e         act;
    logic [IDX_W-1:0]         idx;
    logic signed [PEER_W-1:0] peer;
    if ($urandom_range(99) < add_pct) begin
      act = csa_pkg::ACT_ADD;
    end else begin
      case ($urandom_range(2))
        0: act = csa_pkg::ACT_FREE;
        1: act = csa_pkg::ACT_REMOVE;
        default: act = csa_pkg::ACT_GET;
      endcase
    end
    idx  = ($urandom_range(99) < 75) ? pick_used_slot() : IDX_W'($urandom_range(SLOTS - 1));
    peer = pick_peer();
    // removes mostly aim at an address that is in the table
    if (act == csa_pkg::ACT_REMOVE && free_cnt < SLOTS && $urandom_range(99) < 65) begin
      peer = tbl_peer[pick_used_slot()];
    end
    send_word(act, peer, idx);
  endtask

  // ---------------------------------------------------------------- tests

  // empty-table errors, extreme addresses, duplicates, lifo reuse
  task automatic test_directed();
    send_word(csa_pkg::ACT_GET,    '0, '0);
    send_word(csa_pkg::ACT_FREE,   '0, IDX_W'(SLOTS - 1));
    send_word(csa_pkg::ACT_REMOVE, '0, '0);
    send_word(csa_pkg::ACT_ADD,    PEER_MIN, '1);
    send_word(csa_pkg::ACT_ADD,    PEER_MAX, '0);
    send_word(csa_pkg::ACT_ADD,    '0, '0);
    send_word(csa_pkg::ACT_ADD,    PEER_ONES, '0);
    send_word(csa_pkg::ACT_ADD,    PEER_MAX, '0);
    send_word(csa_pkg::ACT_GET,    '0, 6'd0);
    send_word(csa_pkg::ACT_GET,    '0, 6'd3);
    send_word(csa_pkg::ACT_GET,    '0, 6'd4);
    send_word(csa_pkg::ACT_REMOVE, PEER_MAX, '0);
    send_word(csa_pkg::ACT_REMOVE, PEER_MAX, '0);
    // stale address of freed slots must not match
    send_word(csa_pkg::ACT_REMOVE, PEER_MAX, '0);
    send_word(csa_pkg::ACT_REMOVE, PEER_ONES, '0);
    send_word(csa_pkg::ACT_FREE,   '0, 6'd2);
    send_word(csa_pkg::ACT_FREE,   '0, 6'd2);
    send_word(csa_pkg::ACT_ADD,    32'sh1234_5678, '0);
    send_word(csa_pkg::ACT_GET,    '0, 6'd2);
    send_word(csa_pkg::ACT_GET,    '0, 6'd1);
    send_word(csa_pkg::ACT_FREE,   '0, 6'd0);
    send_word(csa_pkg::ACT_GET,    '0, IDX_W'(SLOTS - 1));
    drain_results();
  endtask

  // fill up, hit the full case, then empty the table again
  task automatic test_full_table();
    int i;
    while (free_cnt > 0) begin
      send_word(csa_pkg::ACT_ADD, pick_peer(), IDX_W'($urandom_range(SLOTS - 1)));
    end
    for (i = 0; i < 3; i++) send_word(csa_pkg::ACT_ADD, pick_peer(), '1);
    send_word(csa_pkg::ACT_GET, '0, pick_used_slot());
    send_word(csa_pkg::ACT_FREE, '0, pick_used_slot());
    send_word(csa_pkg::ACT_ADD, PEER_MAX, '0);
    send_word(csa_pkg::ACT_ADD, PEER_MIN, '0);
    while (free_cnt < SLOTS) begin
      if ($urandom_range(1) == 0) begin
        send_word(csa_pkg::ACT_FREE, pick_peer(), pick_used_slot());
      end else begin
        send_word(csa_pkg::ACT_REMOVE, tbl_peer[pick_used_slot()],
                  IDX_W'($urandom_range(SLOTS - 1)));
      end
    end
  endtask

  // random traffic swinging between filling and draining the table
  task automatic test_random_mix();
    int seg;
    int n;
    for (seg = 0; seg < 10; seg++) begin
      for (n = 0; n < 130; n++) begin
        case (seg % 3)
          0: send_random_word(55);
          1: send_random_word(20);
          default: send_random_word(80);
        endcase
      end
      if (seg == 4) drain_results();
    end
  endtask

  // back-to-back traffic with no stalls on either side
  task automatic test_no_idle();
    int n;
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    for (n = 0; n < 200; n++) send_random_word(40);
    drain_results();
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    int i;
    rst_n               = 1'b0;
    req_if.valid        = 1'b0;
    req_if.action       = csa_pkg::ACT_ADD;
    req_if.peer_address = '0;
    req_if.slot_index   = '0;
    rsp_if.ready        = 1'b0;
    send_idle_en        = 1'b1;
    recv_idle_en        = 1'b1;
    for (i = 0; i < POOL_SIZE; i++) peer_pool[i] = $urandom();
    table_reset();

    repeat (RESET_LEN) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_full_table();
    test_random_mix();
    test_no_idle();

    drain_results();
    repeat (SLOTS + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
